>>> design/rgbconv_pkg.sv
// ----------------------------------------------------------------------------
// rgbconv_pkg
// shared types and constants of the rgb image convolution unit
// ----------------------------------------------------------------------------
package rgbconv_pkg;

  localparam int PIX_W  = 24;
  localparam int WT_W   = 16;
  localparam int GAIN_W = 24;
  localparam int OFFS_W = 24;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 48;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd2;
  localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [2:0] REG_NORM_MODE     = 3'd4;
  localparam logic [2:0] REG_KERNEL_OFFSET = 3'd5;
  localparam logic [2:0] REG_NORM_GAIN     = 3'd6;
  localparam logic [2:0] REG_ABS_GAIN      = 3'd7;

  typedef struct packed {
    logic            wload;
    logic [4:0]      widx;
    logic [WT_W-1:0] wval;
    logic            shift;
    logic            rot;
    logic            clr;
    logic            mac_en;
    logic [3:0]      kh;
  } ctl_t;

endpackage

>>> design/rgbconv_lstore.sv
// ----------------------------------------------------------------------------
// rgbconv_lstore
// one line of pixel storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rgbconv_lstore #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [rgbconv_pkg::PIX_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [rgbconv_pkg::PIX_W-1:0] rdata
);
  import rgbconv_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/rgbconv_cell.sv
// ----------------------------------------------------------------------------
// rgbconv_cell
// one kernel row: window row, weight row and a rotating multiply-accumulate
// ----------------------------------------------------------------------------
module rgbconv_cell #(
  parameter int M     = 5,
  parameter int ROW   = 0,
  parameter int SUM_W = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rgbconv_pkg::ctl_t             ctl,
  input  logic [rgbconv_pkg::PIX_W-1:0] pix_in,
  input  logic signed [SUM_W-1:0]       sum_in  [3],
  output logic signed [SUM_W-1:0]       sum_out [3]
);
  import rgbconv_pkg::*;

  logic [PIX_W-1:0]       pw  [M];
  logic signed [WT_W-1:0] w   [M];
  logic signed [SUM_W-1:0] acc [3];
  logic signed [24:0]     prod [3];
  logic                   row_en;

  assign row_en = ROW < int'(ctl.kh);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = w[0] * $signed({1'b0, pw[0][8*c +: 8]});
      sum_out[c] = sum_in[c] + acc[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < M; j++) begin
        pw[j] <= '0;
        w[j]  <= '0;
      end
      for (int c = 0; c < 3; c++) begin
        acc[c] <= '0;
      end
    end else begin
      if (ctl.wload) begin
        for (int j = 0; j < M; j++) begin
          if (int'(ctl.widx) == ROW * M + j) begin
            w[j] <= ctl.wval;
          end
        end
      end
      if (ctl.shift) begin
        pw[0] <= pix_in;
        for (int j = 1; j < M; j++) begin
          pw[j] <= pw[j-1];
        end
      end
      if (ctl.clr) begin
        for (int c = 0; c < 3; c++) begin
          acc[c] <= '0;
        end
      end
      if (ctl.rot) begin
        for (int j = 0; j < M - 1; j++) begin
          pw[j] <= pw[j+1];
          w[j]  <= w[j+1];
        end
        pw[M-1] <= pw[0];
        w[M-1]  <= w[0];
        if (ctl.mac_en && row_en) begin
          for (int c = 0; c < 3; c++) begin
            acc[c] <= acc[c] + SUM_W'(prod[c]);
          end
        end
      end
    end
  end

endmodule

>>> design/rgb_image_convolution_unit.sv
// ----------------------------------------------------------------------------
// rgb_image_convolution_unit
// streaming rgb kernel convolution with line stores and a chain of row cells
// ----------------------------------------------------------------------------
// input stream: tuser is the operation (0 weight word, 1 pixel word); tdata
// carries weight index, weight value and the three samples. pixels arrive in
// raster order. configuration words must be written on the cfg channel while
// idle; the unit itself does not enforce this. one result word leaves on the
// output stream per interior center pixel. a weight word is taken in the idle
// state. a pixel word with no result passes accept and window shift. a pixel
// word with a result passes accept, window shift, a rotation through the
// kernel columns in the row cells, row sum, offset/magnitude, split gain
// multiply and clamp into the output register.
// reset clears counters, window, weights and config registers to defaults;
// line stores are not cleared. a stalled receiver holds the output word and
// the unit waits in its last step until the word is taken; the next input
// word is still accepted while an earlier result waits.
// ----------------------------------------------------------------------------
module rgb_image_convolution_unit #(
  parameter int MAX_LINE   = 1024,
  parameter int MAX_KERNEL = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [23:0]                   cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // weight_index, weight_value, in_red, in_green, in_blue
  input  logic [rgbconv_pkg::IN_W-1:0]  s_axis_tdata,
  // operation
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_red, out_green, out_blue, out_row, out_col
  output logic [rgbconv_pkg::OUT_W-1:0] m_axis_tdata
);
  import rgbconv_pkg::*;

  localparam int M     = MAX_KERNEL;
  localparam int LINES = (M > 1) ? M - 1 : 1;
  localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CW    = $clog2(MAX_LINE);
  localparam int KB    = $clog2(M + 1);
  localparam int SUM_W = 25 + $clog2(M * M);
  localparam int A_W   = SUM_W + 1;
  localparam int VW    = A_W + 24;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [10:0] image_width, image_height;
  logic [2:0]  kernel_width, kernel_height;
  logic        normalize_mode;
  logic signed [OFFS_W-1:0] kernel_offset;
  logic [GAIN_W-1:0] norm_gain, abs_gain;

  logic [2:0] state;
  logic [KB-1:0] k;
  logic [CW-1:0] col_count;
  logic [10:0]   row_count;
  logic [SW-1:0] slot;
  logic [SW-1:0] rd_slot;
  logic [PIX_W-1:0] pix;
  logic          has_res;
  logic [9:0]    res_row, res_col;
  logic signed [SUM_W-1:0] total [3];
  logic [A_W-1:0]  mag [3];
  logic [GAIN_W-1:0] gain;
  logic [A_W+11:0] p_lo [3];
  logic [A_W+11:0] p_hi [3];

  logic [CW:0]   w_lim;
  logic [11:0]   h_lim;
  logic [KB-1:0] kw, kh;
  logic          pix_acc, wt_acc;
  logic          res_now;
  logic [11:0]   cr12, cc12;
  logic [PIX_W-1:0] rd [LINES];
  logic [PIX_W-1:0] col_in [M];
  logic [7:0]    q [3];
  ctl_t          ctl;
  logic signed [SUM_W-1:0] chain [M+1][3];

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign pix_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PIXEL);
  assign wt_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WEIGHT);

  always_comb begin
    if (image_width == 11'd0) begin
      w_lim = (CW+1)'(1);
    end else if (int'(image_width) > MAX_LINE) begin
      w_lim = (CW+1)'(MAX_LINE);
    end else begin
      w_lim = (CW+1)'(image_width);
    end
    h_lim = (image_height == 11'd0) ? 12'd1 : {1'b0, image_height};
    if (kernel_width == 3'd0) begin
      kw = KB'(1);
    end else if (int'(kernel_width) > M) begin
      kw = KB'(M);
    end else begin
      kw = KB'(kernel_width);
    end
    if (kernel_height == 3'd0) begin
      kh = KB'(1);
    end else if (int'(kernel_height) > M) begin
      kh = KB'(M);
    end else begin
      kh = KB'(kernel_height);
    end
  end

  always_comb begin
    cr12 = {1'b0, row_count} - 12'(kh - 12'd1 - 12'(kh >> 1));
    cc12 = 12'(col_count) - 12'(kw - 12'd1 - 12'(kw >> 1));
    res_now = ((12'(row_count) + 12'd1) >= 12'(kh))
           && ((12'(col_count) + 12'd1) >= 12'(kw))
           && ((cr12 + 12'(kh >> 1)) < h_lim)
           && ((cc12 + 12'(kw >> 1)) < 12'(w_lim));
  end

  // line stores
  genvar l;
  generate
    for (l = 0; l < LINES; l++) begin : g_line
      rgbconv_lstore #(
        .DEPTH (MAX_LINE),
        .AW    (CW)
      ) u_line (
        .clk   (clk),
        .we    (pix_acc && (M > 1) && (int'(slot) == l)),
        .waddr (col_count),
        .wdata (s_axis_tdata[44:21]),
        .raddr (col_count),
        .rdata (rd[l])
      );
    end
  endgenerate

  always_comb begin
    col_in[0] = pix;
    for (int i = 1; i < M; i++) begin
      if (int'(rd_slot) >= i) begin
        col_in[i] = rd[SW'(int'(rd_slot) - i)];
      end else begin
        col_in[i] = rd[SW'(int'(rd_slot) + LINES - i)];
      end
    end
  end

  // cell control
  always_comb begin
    ctl.wload  = wt_acc;
    ctl.widx   = s_axis_tdata[4:0];
    ctl.wval   = s_axis_tdata[20:5];
    ctl.shift  = (state == S_SHIFT);
    ctl.clr    = (state == S_SHIFT);
    ctl.rot    = (state == S_MAC);
    ctl.mac_en = (k < kw);
    ctl.kh     = 4'(kh);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chain[0][c] = '0;
    end
  end

  genvar r;
  generate
    for (r = 0; r < M; r++) begin : g_cell
      rgbconv_cell #(
        .M     (M),
        .ROW   (r),
        .SUM_W (SUM_W)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .pix_in  (col_in[r]),
        .sum_in  (chain[r]),
        .sum_out (chain[r+1])
      );
    end
  endgenerate

  // scale and clamp
  always_comb begin
    logic [VW-1:0] v;
    for (int c = 0; c < 3; c++) begin
      v = (VW'(p_hi[c]) << 12) + VW'(p_lo[c]);
      q[c] = (|v[VW-1:40]) ? 8'd255 : v[39:32];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 11'd1024;
      image_height   <= 11'd1024;
      kernel_width   <= 3'd3;
      kernel_height  <= 3'd3;
      normalize_mode <= 1'b0;
      kernel_offset  <= '0;
      norm_gain      <= '1;
      abs_gain       <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width    <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  image_height   <= cfg_data[10:0];
        REG_KERNEL_WIDTH:  kernel_width   <= cfg_data[2:0];
        REG_KERNEL_HEIGHT: kernel_height  <= cfg_data[2:0];
        REG_NORM_MODE:     normalize_mode <= cfg_data[0];
        REG_KERNEL_OFFSET: kernel_offset  <= cfg_data;
        REG_NORM_GAIN:     norm_gain      <= cfg_data;
        REG_ABS_GAIN:      abs_gain       <= cfg_data;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    logic signed [A_W-1:0] t;
    if (rst) begin
      state         <= S_IDLE;
      k             <= '0;
      col_count     <= '0;
      row_count     <= '0;
      slot          <= '0;
      has_res       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pix_acc) begin
            pix     <= s_axis_tdata[44:21];
            rd_slot <= slot;
            has_res <= res_now;
            res_row <= cr12[9:0];
            res_col <= cc12[9:0];
            state   <= S_SHIFT;
            if ((CW+1)'(col_count) + (CW+1)'(1) >= w_lim) begin
              col_count <= '0;
              if (12'(row_count) + 12'd1 >= h_lim) begin
                row_count <= '0;
                slot      <= '0;
              end else begin
                row_count <= row_count + 11'd1;
                slot      <= (int'(slot) == LINES - 1) ? '0 : slot + SW'(1);
              end
            end else begin
              col_count <= col_count + CW'(1);
            end
          end
        end
        S_SHIFT: begin
          k     <= '0;
          state <= has_res ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if (k == KB'(M - 1)) begin
            state <= S_SUM;
          end else begin
            k <= k + KB'(1);
          end
        end
        S_SUM: begin
          for (int c = 0; c < 3; c++) begin
            total[c] <= chain[M][c];
          end
          state <= S_SCALE;
        end
        S_SCALE: begin
          for (int c = 0; c < 3; c++) begin
            if (normalize_mode) begin
              t = A_W'(total[c]) + A_W'(kernel_offset);
            end else begin
              t = (total[c] < 0) ? -A_W'(total[c]) : A_W'(total[c]);
            end
            mag[c] <= (t > 0) ? t : '0;
          end
          gain  <= normalize_mode ? norm_gain : abs_gain;
          state <= S_MUL;
        end
        S_MUL: begin
          for (int c = 0; c < 3; c++) begin
            p_lo[c] <= mag[c] * (A_W+12)'(gain[11:0]);
            p_hi[c] <= mag[c] * (A_W+12)'(gain[23:12]);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {4'd0, res_col, res_row, q[2], q[1], q[0]};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/tb_rgb_image_convolution_unit.sv
// ----------------------------------------------------------------------------
// tb_rgb_image_convolution_unit
// self-checking bench for the streaming rgb kernel convolution unit
// ----------------------------------------------------------------------------
// a local model of line stores, window and kernel predicts every filtered
// pixel; results are checked field by field in order. directed images cover
// the sample and weight extremes, then size corner cases, row wrap, a full
// width line and random images with random scaling. both stream sides idle
// at random; the configuration is only written once the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_image_convolution_unit;
  import rgbconv_pkg::*;

  localparam int LIMIT = 600000;
  localparam int NLINES = 4;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } conv_pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  rgb_image_convolution_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers
  logic [10:0]        img_w = 11'd1024;
  logic [10:0]        img_h = 11'd1024;
  logic [2:0]         ker_w = 3'd3;
  logic [2:0]         ker_h = 3'd3;
  logic               norm_mode = 1'b0;
  logic signed [23:0] ker_offs = '0;
  logic [23:0]        norm_gain = 24'hFFFFFF;
  logic [23:0]        abs_gain = 24'hFFFFFF;

  // shadow datapath state
  logic [23:0]        line_mem [NLINES][1024];
  logic [23:0]        window [5][5];
  logic signed [15:0] weights [25];
  int unsigned        row_cnt = 0;
  int unsigned        col_cnt = 0;

  conv_pixel_t expected_pixels[$];
  int  errors = 0;
  int  words_sent = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;

  initial begin
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (window[i, j]) window[i][j] = '0;
    foreach (weights[i]) weights[i] = '0;
  end

  function automatic logic [7:0] scale_sum(longint s);
    longint v;
    longint q;
    if (norm_mode) v = (s + longint'(ker_offs)) * longint'(norm_gain);
    else v = (s < 0 ? -s : s) * longint'(abs_gain);
    if (v <= 0) return 8'd0;
    q = v >>> 32;
    return q > 255 ? 8'd255 : q[7:0];
  endfunction

  task automatic predict_word(logic op, logic [47:0] d);
    int unsigned w, h, kw, kh, slot, cr, cc;
    logic [23:0] column [5];
    longint s [3];
    conv_pixel_t r;
    if (op == OP_WEIGHT) begin
      if (d[4:0] < 25) weights[d[4:0]] = d[20:5];
      return;
    end
    w = img_w == 0 ? 1 : (img_w > 1024 ? 1024 : img_w);
    h = img_h == 0 ? 1 : img_h;
    kw = ker_w == 0 ? 1 : (ker_w > 5 ? 5 : ker_w);
    kh = ker_h == 0 ? 1 : (ker_h > 5 ? 5 : ker_h);
    slot = row_cnt % NLINES;
    column[0] = d[44:21];
    for (int i = 1; i < 5; i++) column[i] = line_mem[(slot + NLINES - i) % NLINES][col_cnt];
    line_mem[slot][col_cnt] = d[44:21];
    for (int i = 0; i < 5; i++) begin
      for (int j = 4; j > 0; j--) window[i][j] = window[i][j-1];
      window[i][0] = column[i];
    end
    if (row_cnt + 1 >= kh && col_cnt + 1 >= kw) begin
      cr = row_cnt - (kh - 1 - kh / 2);
      cc = col_cnt - (kw - 1 - kw / 2);
      if (cr + kh / 2 < h && cc + kw / 2 < w) begin
        s = '{0, 0, 0};
        for (int kr = 0; kr < kh; kr++)
          for (int kc = 0; kc < kw; kc++)
            for (int ch = 0; ch < 3; ch++)
              s[ch] += longint'(weights[kr*5+kc]) * int'(window[kr][kc][8*ch +: 8]);
        r.red = scale_sum(s[0]);
        r.green = scale_sum(s[1]);
        r.blue = scale_sum(s[2]);
        r.row = cr[9:0];
        r.col = cc[9:0];
        expected_pixels.push_back(r);
      end
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endtask

  task automatic send_word(logic op, logic [47:0] d);
    while (idle_on && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    predict_word(op, d);
    words_sent++;
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_word(OP_PIXEL, {3'b0, b, g, r, 16'($urandom), 5'($urandom)});
  endtask

  task automatic send_weight(logic [4:0] idx, logic [15:0] val);
    send_word(OP_WEIGHT, {3'b0, 24'($urandom), val, idx});
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   img_w = val[10:0];
      REG_IMAGE_HEIGHT:  img_h = val[10:0];
      REG_KERNEL_WIDTH:  ker_w = val[2:0];
      REG_KERNEL_HEIGHT: ker_h = val[2:0];
      REG_NORM_MODE:     norm_mode = val[0];
      REG_KERNEL_OFFSET: ker_offs = val;
      REG_NORM_GAIN:     norm_gain = val;
      REG_ABS_GAIN:      abs_gain = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h, int kw, int kh);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 24'(w));
    write_reg(REG_IMAGE_HEIGHT, 24'(h));
    write_reg(REG_KERNEL_WIDTH, 24'(kw));
    write_reg(REG_KERNEL_HEIGHT, 24'(kh));
  endtask

  task automatic set_scaling(logic mode, logic [23:0] offs, logic [23:0] ng, logic [23:0] ag);
    wait_drained();
    write_reg(REG_NORM_MODE, {23'd0, mode});
    write_reg(REG_KERNEL_OFFSET, offs);
    write_reg(REG_NORM_GAIN, ng);
    write_reg(REG_ABS_GAIN, ag);
  endtask

  function automatic logic [23:0] rand_gain();
    return 24'($urandom) >> $urandom_range(16);
  endfunction

  task automatic random_scaling();
    logic [23:0] offs;
    offs = $signed(24'($urandom)) >>> $urandom_range(23);
    set_scaling(1'($urandom_range(1)), offs, rand_gain(), rand_gain());
  endtask

  task automatic random_kernel(int n);
    repeat (n) send_weight(5'($urandom), 16'($urandom));
  endtask

  // whole images only, so the line stores always hold rows of this image
  task automatic send_images(int n, int weight_pct);
    int w, h;
    w = img_w == 0 ? 1 : (img_w > 1024 ? 1024 : img_w);
    h = img_h == 0 ? 1 : img_h;
    repeat (n * w * h) begin
      if ($urandom_range(99) < weight_pct) send_weight(5'($urandom), 16'($urandom));
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_directed();
    logic [7:0] v;
    set_geometry(4, 4, 3, 3);
    set_scaling(1'b0, 24'd0, 24'hFFFFFF, 24'h01_0000);
    send_weight(5'd0, 16'h8000);
    send_weight(5'd6, 16'h0100);
    send_weight(5'd12, 16'h7FFF);
    send_weight(5'd24, 16'h7FFF);
    send_weight(5'd31, 16'hFFFF);
    for (int i = 0; i < 16; i++) begin
      v = (i % 3 == 0) ? 8'hFF : 8'h00;
      send_pixel(v, ~v, (i % 2) ? 8'hFF : 8'h00);
    end
  endtask

  task automatic test_scaling_extremes();
    set_scaling(1'b1, 24'h800000, 24'hFFFFFF, 24'd0);
    send_images(1, 10);
    set_scaling(1'b1, 24'h7FFFFF, 24'd0, 24'hFFFFFF);
    send_images(1, 10);
    set_scaling(1'b1, 24'h000100, 24'h002000, 24'hFFFFFF);
    send_images(1, 10);
  endtask

  task automatic test_sizes();
    int geo [7][4] = '{'{1, 1, 1, 1}, '{0, 0, 0, 0}, '{5, 4, 2, 4}, '{3, 3, 5, 5},
                       '{6, 5, 7, 6}, '{2, 3, 1, 3}, '{7, 6, 4, 2}};
    for (int i = 0; i < 7; i++) begin
      set_geometry(geo[i][0], geo[i][1], geo[i][2], geo[i][3]);
      random_scaling();
      random_kernel(12);
      send_images(1, 5);
    end
  endtask

  // tall image left part way, then one-line images wrap the row counter
  task automatic test_row_wrap();
    set_geometry(3, 2047, 3, 3);
    send_images(0, 0);
    repeat (15) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    set_geometry(3, 1, 1, 1);
    send_images(2, 0);
  endtask

  // full width line, sent with no idling on either side
  task automatic test_full_line();
    set_geometry(1500, 1, 5, 1);
    random_kernel(10);
    idle_on = 1'b0;
    send_images(1, 0);
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    do begin
      set_geometry($urandom_range(1, 12), $urandom_range(1, 9),
                   $urandom_range(0, 7), $urandom_range(0, 7));
      random_scaling();
      random_kernel($urandom_range(4, 30));
      send_images($urandom_range(1, 2), 3);
    end while (words_sent < 1400);
  endtask

  always @(posedge clk) begin
    conv_pixel_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[43:0];
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.row !== want.row || got.col !== want.col) begin
          errors++;
          if (errors <= 10)
            $display("mismatch rgb %h %h %h at %0d,%0d, got %h %h %h at %0d,%0d",
                     want.red, want.green, want.blue, want.row, want.col,
                     got.red, got.green, got.blue, got.row, got.col);
        end
      end
    end
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[rgb_image_convolution_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_scaling_extremes();
    test_sizes();
    test_row_wrap();
    test_full_line();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("[rgb_image_convolution_unit] OK");
    end else begin
      $display("[rgb_image_convolution_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> rgb_image_convolution_unit.f
design/rgbconv_pkg.sv
design/rgbconv_lstore.sv
design/rgbconv_cell.sv
design/rgb_image_convolution_unit.sv
tb/tb_rgb_image_convolution_unit.sv
